>>> src/ffea_pkg.sv
`default_nettype none
package ffea_pkg;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_INVALID = 3'd2,
        ST_FULL    = 3'd3,
        ST_IGNORED = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_PREP2,
        S_SC_RD,
        S_SC_CLIP,
        S_SC_FIT,
        S_DECIDE,
        S_RM_RD,
        S_RM_WR,
        S_RM_FIN,
        S_PU_START,
        S_PU_RD,
        S_PU_WR,
        S_PU_INS,
        S_DONE
    } t_state;

    localparam int unsigned IN_DATA_W  = 136;
    localparam int unsigned OUT_DATA_W = 40;

endpackage
`default_nettype wire

>>> src/first_fit_extent_allocator_unit.sv
// First-fit extent allocator.
// Input channel (s_axis): one item per request. tuser is the action (0 allocate,
// 1 free); tdata carries size, alignment, window and free address.
// Output channel (m_axis): one item per request with status and allocated address.
// The free-extent table lives in two single-port-write synchronous RAMs
// (start and length) with one registered read port; entry 0 is the list front.
// A free moves every entry down one slot through the RAM before the new front
// is written. An allocate scans the entries in turn, then either shortens the
// hit entry to its head part or removes it (moving each following entry up one
// slot), and may push the tail part to the front in the same way as a free.
// One item is handled at a time and the input is ready again as soon as the
// result is registered.
// Reset empties the table (count cleared) and drops any pending result.
// A finished result waits in the output register; the next item is accepted
// as soon as the block is idle, but a further result waits until the
// receiver has taken the previous one.
`default_nettype none
module first_fit_extent_allocator_unit
    import ffea_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned ADDR_WIDTH  = 32,
    parameter int unsigned MIN_ALIGN   = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // req_size[31:0], align_log2[36:32], window_low[68:37], window_high[100:69],
    // free_addr[132:101], zero fill
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // status[2:0], alloc_addr[34:3], zero fill
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int unsigned AW = ADDR_WIDTH;
    localparam int unsigned XW = ((ADDR_WIDTH > 32) ? ADDR_WIDTH : 32) + 2;
    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned LW = $clog2(MIN_ALIGN);
    localparam logic [XW-1:0] AM  = {{(XW-AW){1'b0}}, {AW{1'b1}}};
    localparam logic [XW-1:0] MSK = XW'(MIN_ALIGN - 1);
    localparam logic [XW-1:0] MINA = XW'(MIN_ALIGN);
    localparam logic [CW-1:0] DEPTH = CW'(TABLE_DEPTH);

    logic [AW-1:0] mem_start [TABLE_DEPTH];
    logic [AW-1:0] mem_len   [TABLE_DEPTH];

    t_state r_state, n_state;
    logic          r_action;
    logic [31:0]   r_req;
    logic [4:0]    r_alog;
    logic [XW-1:0] r_wl, r_wh, r_fa;
    logic [XW-1:0] r_lo, n_lo, r_hi, n_hi, r_size, n_size, r_amk, n_amk;
    logic [XW-1:0] r_st, n_st, r_len, n_len, r_cs, n_cs, r_ce, n_ce, r_sa, n_sa;
    logic [XW-1:0] r_ps, n_ps, r_pl, n_pl;
    logic          r_tail, n_tail;
    logic [CW-1:0] r_idx, n_idx, r_cnt, n_cnt;
    t_status       r_res_st, n_res_st;
    logic [31:0]   r_res_addr, n_res_addr;
    logic          r_ovalid;
    t_status       r_ost;
    logic [31:0]   r_oaddr;

    logic [AW-1:0] rd_start, rd_len;
    logic [IW-1:0] ra, wa;
    logic          we_s, we_l;
    logic [AW-1:0] wd_s, wd_l;

    logic [XW-1:0] base, end_x, h1, al, head, tail, len_f, room, tmp, fit_sa, sel;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_oaddr, r_ost};

    always_ff @(posedge i_clk) begin
        if (we_s) begin
            mem_start[wa] <= wd_s;
        end
        if (we_l) begin
            mem_len[wa] <= wd_l;
        end
        rd_start <= mem_start[ra];
        rd_len   <= mem_len[ra];
    end

    always_comb begin
        sel    = r_action ? r_fa : r_wl;
        base   = (sel < MINA) ? MINA : sel;
        h1     = (r_wh + XW'(1)) & ~MSK;
        al     = XW'(1) << r_alog;
        if (al < MINA) begin
            al = MINA;
        end
        tmp    = r_lo - r_fa;
        len_f  = (XW'(r_req) - tmp) & ~MSK;
        room   = AM - r_lo + XW'(1);
        end_x  = XW'(rd_start) + XW'(rd_len) - XW'(1);
        fit_sa = (r_cs + r_amk) & ~r_amk;
        head   = r_sa - r_st;
        tail   = (r_st + r_len) - (r_sa + r_size);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: n_state = S_PREP2;
            S_PREP2: begin
                if (r_action) begin
                    if (r_lo > AM || tmp >= XW'(r_req)) begin
                        n_state = S_DONE;
                    end else if (((len_f > room) ? (room & ~MSK) : len_f) == '0
                                 || r_cnt == DEPTH) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_PU_START;
                    end
                end else if (r_lo > AM || r_req == 32'd0
                             || (r_wh != AM && h1 == '0)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SC_RD;
                end
            end
            S_SC_RD: n_state = (r_idx == r_cnt) ? S_DONE : S_SC_CLIP;
            S_SC_CLIP: n_state = S_SC_FIT;
            S_SC_FIT: begin
                if (r_ce < r_cs || r_ce < fit_sa
                    || (r_ce - fit_sa + XW'(1)) < r_size) begin
                    n_state = S_SC_RD;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (head != '0 && tail != '0 && r_cnt == DEPTH) begin
                    n_state = S_DONE;
                end else if (head != '0) begin
                    n_state = (tail != '0) ? S_PU_START : S_DONE;
                end else begin
                    n_state = ((r_idx + CW'(1)) < r_cnt) ? S_RM_RD : S_RM_FIN;
                end
            end
            S_RM_RD: n_state = S_RM_WR;
            S_RM_WR: n_state = ((r_idx + CW'(2)) < r_cnt) ? S_RM_RD : S_RM_FIN;
            S_RM_FIN: n_state = r_tail ? S_PU_START : S_DONE;
            S_PU_START: n_state = (r_cnt == '0) ? S_PU_INS : S_PU_RD;
            S_PU_RD: n_state = S_PU_WR;
            S_PU_WR: n_state = (r_idx == CW'(1)) ? S_PU_INS : S_PU_RD;
            S_PU_INS: n_state = S_DONE;
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_lo = r_lo; n_hi = r_hi; n_size = r_size; n_amk = r_amk;
        n_st = r_st; n_len = r_len; n_cs = r_cs; n_ce = r_ce; n_sa = r_sa;
        n_ps = r_ps; n_pl = r_pl; n_tail = r_tail;
        n_idx = r_idx; n_cnt = r_cnt;
        n_res_st = r_res_st; n_res_addr = r_res_addr;
        ra = r_idx[IW-1:0];
        wa = r_idx[IW-1:0];
        we_s = 1'b0; we_l = 1'b0;
        wd_s = r_ps[AW-1:0]; wd_l = r_pl[AW-1:0];
        unique case (r_state)
            S_PREP: begin
                n_lo = (base + MSK) & ~MSK;
                n_res_addr = 32'd0;
            end
            S_PREP2: begin
                n_size = (XW'(r_req) + MSK) & ~MSK;
                n_hi = (r_wh == AM) ? AM : (h1 - XW'(1));
                n_amk = al - XW'(1);
                n_idx = '0;
                if (r_action) begin
                    n_ps = r_lo;
                    n_pl = (len_f > room) ? (room & ~MSK) : len_f;
                    if (r_lo > AM || tmp >= XW'(r_req) || n_pl == '0) begin
                        n_res_st = ST_IGNORED;
                    end else if (r_cnt == DEPTH) begin
                        n_res_st = ST_FULL;
                    end else begin
                        n_res_st = ST_OK;
                    end
                end else if (r_lo > AM || r_req == 32'd0) begin
                    n_res_st = ST_INVALID;
                end else begin
                    n_res_st = ST_NOFIT;
                end
            end
            S_SC_CLIP: begin
                n_st  = XW'(rd_start);
                n_len = XW'(rd_len);
                n_cs  = (XW'(rd_start) > r_lo) ? XW'(rd_start) : r_lo;
                n_ce  = (end_x < r_hi) ? end_x : r_hi;
            end
            S_SC_FIT: begin
                n_sa = fit_sa;
                if (r_ce < r_cs || r_ce < fit_sa
                    || (r_ce - fit_sa + XW'(1)) < r_size) begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_DECIDE: begin
                n_ps = r_sa + r_size;
                n_pl = tail;
                n_tail = (tail != '0);
                if (head != '0 && tail != '0 && r_cnt == DEPTH) begin
                    n_res_st = ST_FULL;
                end else begin
                    n_res_st = ST_OK;
                    n_res_addr = r_sa[31:0];
                    if (head != '0) begin
                        we_l = 1'b1;
                        wd_l = head[AW-1:0];
                    end
                end
            end
            S_RM_RD: ra = IW'(r_idx + CW'(1));
            S_RM_WR: begin
                we_s = 1'b1; we_l = 1'b1;
                wd_s = rd_start; wd_l = rd_len;
                n_idx = r_idx + CW'(1);
            end
            S_RM_FIN: n_cnt = r_cnt - CW'(1);
            S_PU_START: n_idx = r_cnt;
            S_PU_RD: ra = IW'(r_idx - CW'(1));
            S_PU_WR: begin
                we_s = 1'b1; we_l = 1'b1;
                wd_s = rd_start; wd_l = rd_len;
                n_idx = r_idx - CW'(1);
            end
            S_PU_INS: begin
                wa = '0;
                we_s = 1'b1; we_l = 1'b1;
                n_cnt = r_cnt + CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_action <= s_axis_tuser;
            r_req    <= s_axis_tdata[31:0];
            r_alog   <= s_axis_tdata[36:32];
            r_wl     <= XW'(AW'(s_axis_tdata[68:37]));
            r_wh     <= XW'(AW'(s_axis_tdata[100:69]));
            r_fa     <= XW'(AW'(s_axis_tdata[132:101]));
        end
        if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
            r_ost   <= r_res_st;
            r_oaddr <= r_res_addr;
        end
        r_lo <= n_lo; r_hi <= n_hi; r_size <= n_size; r_amk <= n_amk;
        r_st <= n_st; r_len <= n_len; r_cs <= n_cs; r_ce <= n_ce; r_sa <= n_sa;
        r_ps <= n_ps; r_pl <= n_pl; r_tail <= n_tail; r_idx <= n_idx;
        r_res_st <= n_res_st; r_res_addr <= n_res_addr;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH) else $error("extent count overflow");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_cnt == $past(r_cnt) || r_cnt == $past(r_cnt) + CW'(1)
             || r_cnt == $past(r_cnt) - CW'(1))) else $error("count jumped");

    a_addr_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_oaddr[LW-1:0] == '0) else $error("unaligned result");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ost != ST_OK) |-> r_oaddr == 32'd0)
        else $error("address on failure");
`endif

endmodule
`default_nettype wire

>>> tb/testbench.sv
module testbench;
    import ffea_pkg::*;

    localparam int unsigned DEPTH = 16;
    localparam logic [31:0] ALIGN_MASK = 32'd31;
    localparam logic [31:0] ALIGN_MIN = 32'd32;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef struct packed {
        t_status     status;
        logic [31:0] addr;
    } t_outcome;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [63:0] ext_start [DEPTH];
    logic [63:0] ext_len [DEPTH];
    int unsigned ext_count;
    t_outcome    pending_q[$];
    int unsigned err_count;
    bit          idle_on;
    int unsigned stall_left = 0;

    first_fit_extent_allocator_unit DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void prepend_extent(logic [63:0] s, logic [63:0] l);
        if (ext_count >= DEPTH) return;
        for (int j = DEPTH - 1; j > 0; j--) begin
            if (j <= ext_count) begin
                ext_start[j] = ext_start[j-1];
                ext_len[j] = ext_len[j-1];
            end
        end
        ext_start[0] = s;
        ext_len[0] = l;
        ext_count++;
    endfunction

    function automatic void drop_entry(int unsigned idx);
        for (int unsigned j = idx; j + 1 < ext_count; j++) begin
            ext_start[j] = ext_start[j+1];
            ext_len[j] = ext_len[j+1];
        end
        if (ext_count > 0) ext_count--;
    endfunction

    function automatic t_status release_extent(logic [63:0] fa, logic [63:0] sz);
        logic [63:0] top, m, base, s, gap, len, room;
        top = 64'hFFFF_FFFF;
        m = {32'd0, ALIGN_MASK};
        base = (fa < ALIGN_MIN) ? {32'd0, ALIGN_MIN} : fa;
        s = (base + m) & ~m;
        if (s < base || s > top) return ST_IGNORED;
        gap = s - fa;
        if (gap >= sz) return ST_IGNORED;
        len = (sz - gap) & ~m;
        room = top - s + 1;
        if (len > room) len = room & ~m;
        if (len == 0) return ST_IGNORED;
        if (ext_count >= DEPTH) return ST_FULL;
        prepend_extent(s, len);
        return ST_OK;
    endfunction

    function automatic t_outcome claim_extent(logic [63:0] req, logic [4:0] alog,
                                              logic [63:0] wl, logic [63:0] wh);
        logic [63:0] top, m, base, lo, hi, sz, al, amk, h1;
        logic [63:0] st, len, en, cs, ce, sa, head, tail;
        t_outcome r;
        top = 64'hFFFF_FFFF;
        m = {32'd0, ALIGN_MASK};
        r.status = ST_NOFIT;
        r.addr = '0;
        base = (wl < ALIGN_MIN) ? {32'd0, ALIGN_MIN} : wl;
        lo = (base + m) & ~m;
        if (lo < base || lo > top) begin
            r.status = ST_INVALID;
            return r;
        end
        sz = (req + m) & ~m;
        if (sz == 0) begin
            r.status = ST_INVALID;
            return r;
        end
        if (wh >= top) begin
            hi = top;
        end else begin
            h1 = (wh + 1) & ~m;
            if (h1 == 0) return r;
            hi = h1 - 1;
        end
        al = 64'd1 << alog;
        if (al < ALIGN_MIN) al = {32'd0, ALIGN_MIN};
        amk = al - 1;
        for (int unsigned i = 0; i < ext_count; i++) begin
            st = ext_start[i];
            len = ext_len[i];
            en = st + len - 1;
            cs = (st > lo) ? st : lo;
            ce = (en < hi) ? en : hi;
            if (ce < cs) continue;
            sa = cs + ((al - (cs & amk)) & amk);
            if (sa < cs || ce < sa) continue;
            if (ce - sa + 1 < sz) continue;
            head = sa - st;
            tail = len - head - sz;
            if (head != 0 && tail != 0 && ext_count >= DEPTH) begin
                r.status = ST_FULL;
                return r;
            end
            if (head != 0) ext_len[i] = head;
            else drop_entry(i);
            if (tail != 0) prepend_extent(sa + sz, tail);
            r.status = ST_OK;
            r.addr = sa[31:0];
            return r;
        end
        return r;
    endfunction

    task automatic send_item(t_action act, logic [31:0] sz, logic [4:0] alog,
                             logic [31:0] wl, logic [31:0] wh, logic [31:0] fa);
        t_outcome r;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {3'd0, fa, wh, wl, alog, sz};
        do @(posedge i_clk); while (!s_axis_tready);
        if (act == ACT_FREE) begin
            r.status = release_extent({32'd0, fa}, {32'd0, sz});
            r.addr = '0;
        end else begin
            r = claim_extent({32'd0, sz}, alog, {32'd0, wl}, {32'd0, wh});
        end
        pending_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_outcome exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected item: tdata %h", m_axis_tdata);
                err_count++;
            end else begin
                exp_r = pending_q[0];
                pending_q.delete(0);
                if (m_axis_tdata[2:0] !== exp_r.status) begin
                    $error("status: expected %0d actual %0d", exp_r.status,
                           m_axis_tdata[2:0]);
                    err_count++;
                end
                if (m_axis_tdata[34:3] !== exp_r.addr) begin
                    $error("alloc_addr: expected %h actual %h", exp_r.addr,
                           m_axis_tdata[34:3]);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10);
        end
        if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [31:0] rand_addr();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 4096);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 4096);
            default: return $urandom_range(0, 32'h0010_0000);
        endcase
    endfunction

    task automatic test_directed();
        send_item(ACT_ALLOC, 32'd64, 5'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_item(ACT_FREE, 32'd0, 5'd0, 32'd0, 32'd0, 32'd0);
        send_item(ACT_FREE, 32'd40, 5'd0, 32'd0, 32'd0, 32'd0);
        send_item(ACT_FREE, 32'd4096, 5'd0, 32'd0, 32'd0, 32'd1000);
        send_item(ACT_FREE, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FF00);
        send_item(ACT_FREE, 32'd64, 5'd0, 32'd0, 32'd0, 32'hFFFF_FFF0);
        send_item(ACT_ALLOC, 32'd0, 5'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_item(ACT_ALLOC, 32'd1, 5'd0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd0);
        send_item(ACT_ALLOC, 32'd1, 5'd0, 32'd0, 32'd10, 32'd0);
        send_item(ACT_ALLOC, 32'd1, 5'd0, 32'd2000, 32'd1000, 32'd0);
        send_item(ACT_ALLOC, 32'd32, 5'd31, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_item(ACT_ALLOC, 32'd100, 5'd8, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_item(ACT_ALLOC, 32'hFFFF_FFFF, 5'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_item(ACT_ALLOC, 32'd33, 5'd6, 32'd1100, 32'd2000, 32'd0);
        for (int i = 0; i < 18; i++) begin
            send_item(ACT_FREE, 32'd256, 5'd0, 32'd0, 32'd0, 32'h1000 * (i + 1));
        end
        send_item(ACT_ALLOC, 32'd32, 5'd0, 32'h1040, 32'hFFFF_FFFF, 32'd0);
        send_item(ACT_ALLOC, 32'd32, 5'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
    endtask

    task automatic test_random(int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 45) begin
                send_item(ACT_FREE, ($urandom_range(0, 9) == 0) ? $urandom()
                          : $urandom_range(0, 8192), 5'($urandom()), $urandom(),
                          $urandom(), rand_addr());
            end else if ($urandom_range(0, 9) == 0) begin
                send_item(ACT_ALLOC, $urandom(), 5'($urandom()), rand_addr(),
                          rand_addr(), $urandom());
            end else begin
                send_item(ACT_ALLOC, $urandom_range(0, 2048),
                          5'($urandom_range(0, 10)),
                          $urandom_range(0, 8192),
                          ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF
                          : $urandom_range(4096, 32'h0010_0000), $urandom());
            end
        end
    endtask

    initial begin
        err_count = 0;
        idle_on = 1'b1;
        ext_count = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(750);
        idle_on = 1'b0;
        test_random(170);
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
